// ----- rtl/core/sum_of_totients_top_assert.svh -----
// Assertion macros shared by the sum_of_totients checker files.
`ifndef SUM_OF_TOTIENTS_TOP_ASSERT_SVH
`define SUM_OF_TOTIENTS_TOP_ASSERT_SVH

// Checked at every rising edge outside reset.
`define STOT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stot assertion failed");

// Checked at every rising edge, reset included.
`define STOT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("stot assertion failed");

`endif

// ----- rtl/core/stot_pkg.sv -----
// Shared types for the sum_of_totients block.
`default_nettype none

package stot_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_FINISH
  } stot_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture range, clear sum, k = low
    logic start_k;   // i = 1, gcd operands = (k, 1)
    logic gcd_step;  // one binary gcd step
    logic tally;     // add coprime flag to sum
    logic next_i;    // i = i + 1, gcd operands = (k, i + 1)
    logic next_k;    // k = k + 1
    logic emit;      // copy sum into result register
  } stot_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;     // range low above range high
    logic k_zero;    // current k is zero
    logic last_k;    // current k equals range high
    logic last_i;    // current i equals k
    logic gcd_done;  // gcd decided for current pair
  } stot_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/stot_ctrl.sv -----
// Controller state machine: sequences the k and i loops and the output handshake.
`default_nettype none

module stot_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire stot_pkg::stot_sts_t  sts_i,
  output stot_pkg::stot_cmd_t       cmd_o
);

  stot_pkg::stot_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stot_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      stot_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stot_pkg::ST_CHECK;
        end
      end
      stot_pkg::ST_CHECK: begin
        if (sts_i.empty) begin
          state_d = stot_pkg::ST_FINISH;
        end else if (sts_i.k_zero) begin
          // k = 0 has no candidates
          if (sts_i.last_k) begin
            state_d = stot_pkg::ST_FINISH;
          end else begin
            cmd_o.next_k = 1'b1;
          end
        end else begin
          cmd_o.start_k = 1'b1;
          state_d       = stot_pkg::ST_RUN;
        end
      end
      stot_pkg::ST_RUN: begin
        if (sts_i.gcd_done) begin
          cmd_o.tally = 1'b1;
          if (!sts_i.last_i) begin
            cmd_o.next_i = 1'b1;
          end else if (sts_i.last_k) begin
            state_d = stot_pkg::ST_FINISH;
          end else begin
            cmd_o.next_k = 1'b1;
            state_d      = stot_pkg::ST_CHECK;
          end
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      stot_pkg::ST_FINISH: begin
        // wait until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = stot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stot_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/stot_dp.sv -----
// Datapath: range counters, binary gcd unit, sum accumulator and result register.
`default_nettype none

module stot_dp #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [VALUE_BITS-1:0] range_low_i,
  input  wire logic [VALUE_BITS-1:0] range_high_i,
  input  wire stot_pkg::stot_cmd_t   cmd_i,
  output stot_pkg::stot_sts_t        sts_o,
  output logic [31:0]                totient_sum_o
);

  logic [VALUE_BITS-1:0] hi_q, k_q, i_q, a_q, b_q;
  logic [VALUE_BITS-1:0] i_inc;
  logic [31:0]           sum_q, res_q;
  logic                  empty_q;
  logic                  coprime;

  assign i_inc = i_q + {{(VALUE_BITS-1){1'b0}}, 1'b1};

  // Empty-range flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b0;
    end else if (cmd_i.load) begin
      empty_q <= range_low_i > range_high_i;
    end
  end

  // Loop counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hi_q <= range_high_i;
      k_q  <= range_low_i;
    end else if (cmd_i.next_k) begin
      k_q <= k_q + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end
    if (cmd_i.start_k) begin
      i_q <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end else if (cmd_i.next_i) begin
      i_q <= i_inc;
    end
  end

  // Binary gcd: halve an even operand, else subtract the smaller odd one
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_k) begin
      a_q <= k_q;
      b_q <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end else if (cmd_i.next_i) begin
      a_q <= k_q;
      b_q <= i_inc;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
  end

  // Coprime once b reaches zero with a one; both even means a common factor
  assign coprime = (b_q == '0) && (a_q == {{(VALUE_BITS-1){1'b0}}, 1'b1});

  // Accumulator and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= '0;
    end else if (cmd_i.tally) begin
      sum_q <= sum_q + {31'd0, coprime};
    end
    if (cmd_i.emit) begin
      res_q <= sum_q;
    end
  end

  always_comb begin
    sts_o.empty    = empty_q;
    sts_o.k_zero   = (k_q == '0);
    sts_o.last_k   = (k_q == hi_q);
    sts_o.last_i   = (i_q == k_q);
    sts_o.gcd_done = (b_q == '0) || (!a_q[0] && !b_q[0]);
  end

  assign totient_sum_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/sum_of_totients_top.sv -----
// Top level of the range sum of Euler's totient.
// Each input transfer carries a range low..high; one output transfer returns the sum of
// phi(k) over that range (zero if low > high), modulo 2^32. phi(k) is counted by testing
// every i in 1..k for gcd(k, i) == 1 with a binary gcd unit that takes one step per cycle.
// All pairs share the single gcd unit.
// A request is accepted only while no other is in progress; a finished result waits in an
// output register, so the next request can be taken before the result is collected.
`default_nettype none

module sum_of_totients_top #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [VALUE_BITS-1:0] range_low, [2*VALUE_BITS-1:VALUE_BITS] range_high, zero padded
  input  wire logic [((2*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [31:0] totient_sum
  output logic [31:0]              m_axis_tdata
);

  stot_pkg::stot_cmd_t cmd;
  stot_pkg::stot_sts_t sts;

  stot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stot_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .range_low_i   (s_axis_tdata[VALUE_BITS-1:0]),
    .range_high_i  (s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .totient_sum_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/stot_checker.sv -----
// Port-level checker for sum_of_totients_top and its bind.
`default_nettype none
`include "sum_of_totients_top_assert.svh"

module stot_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // A stalled result stays offered
  `STOT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // A stalled result keeps its value
  `STOT_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

  // One request at a time: ready drops after each input transfer
  `STOT_ASSERT(a_one_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // No result is offered during reset
  `STOT_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind sum_of_totients_top stot_checker u_stot_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- test/sum_of_totients_top_tb.sv -----
// Self-checking testbench for sum_of_totients_top: range totient sums on stream ports.
`default_nettype none

module sum_of_totients_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VB        = 16;
  localparam int unsigned IN_W      = ((2*VB+7)/8)*8;
  localparam int unsigned IDLE_PCT  = 7;
  localparam int unsigned HOLD_LEN  = 3000;
  localparam int unsigned DRAIN_CYC = 64;
  localparam int unsigned MAX_SHOWN = 10;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // [15:0] range_low, [31:16] range_high
  logic [IN_W-1:0] s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // [31:0] totient_sum
  logic [31:0]     m_axis_tdata;

  logic [31:0]     expected_sums[$];
  int unsigned     mismatches    = 0;
  int unsigned     errors        = 0;
  longint unsigned cycle_count   = 0;
  longint unsigned cycle_limit   = 200000;
  bit              steady        = 1'b0;
  int unsigned     hold_req      = 0;
  int unsigned     hold_left;

  sum_of_totients_top #(
    .VALUE_BITS(VB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Euler phi by trial factoring; same count as testing every gcd
  function automatic int unsigned phi_count(input int unsigned k);
    int unsigned rest;
    int unsigned acc;
    int unsigned p;
    if (k == 0) return 0;
    rest = k;
    acc  = k;
    for (p = 2; p * p <= rest; p++) begin
      if (rest % p == 0) begin
        while (rest % p == 0) rest = rest / p;
        acc = acc - acc / p;
      end
    end
    if (rest > 1) acc = acc - acc / rest;
    return acc;
  endfunction

  // Sum of phi over lo..hi, zero for an empty range, wraps at 32 bits
  function automatic logic [31:0] totient_range_sum(input logic [VB-1:0] lo,
                                                    input logic [VB-1:0] hi);
    logic [31:0] sum;
    int unsigned k;
    sum = '0;
    if (lo <= hi) begin
      for (k = lo; k <= hi; k++) sum = sum + phi_count(k);
    end
    return sum;
  endfunction

  // Cycle watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("sum_of_totients_top_tb: errors");
      $finish;
    end
  end

  // Result receiver: random idling, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_req != 0) begin
      hold_left     <= hold_req;
      hold_req      <= 0;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each output transfer with the oldest expected sum
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sums.size() == 0) begin
        errors++;
        if (mismatches < MAX_SHOWN)
          $display("unexpected result: got %0d", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (m_axis_tdata !== want) begin
          errors++;
          if (mismatches < MAX_SHOWN)
            $display("totient_sum mismatch: expected %0d, got %0d", want, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  // Offer one range; the expected sum is queued at the accepting edge
  task automatic send_range(input logic [VB-1:0] lo, input logic [VB-1:0] hi);
    longint unsigned work;
    int unsigned     k;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    // budget: every k needs one check and a gcd run for each of its k candidates
    work = 3;
    if (lo <= hi) begin
      for (k = lo; k <= hi; k++) work += longint'(k) * (4*VB + 2) + 1;
    end
    cycle_limit   += 4 * work + 200;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({hi, lo});
    do @(posedge clk_i); while (!s_axis_tready);
    expected_sums = {expected_sums, totient_range_sum(lo, hi)};
  endtask

  task automatic wait_results();
    while (expected_sums.size() != 0) @(posedge clk_i);
  endtask

  // Empty ranges, including the all-ones pattern in the low field
  task automatic test_empty_ranges();
    send_range(16'd1, 16'd0);
    send_range(16'hFFFF, 16'h0000);
    send_range(16'hFFFF, 16'hFFFE);
    send_range(16'h8000, 16'h7FFF);
    send_range(16'hAAAA, 16'h5555);
    send_range(16'h5556, 16'h5555);
  endtask

  // Small and single-value ranges: zero, one, primes, powers of two
  task automatic test_small_ranges();
    send_range(16'd0, 16'd0);
    send_range(16'd0, 16'd1);
    send_range(16'd1, 16'd1);
    send_range(16'd2, 16'd2);
    send_range(16'd0, 16'd10);
    send_range(16'd7, 16'd7);
    send_range(16'd12, 16'd12);
    send_range(16'd256, 16'd256);
    send_range(16'd997, 16'd997);
    send_range(16'd100, 16'd120);
    send_range(16'd30, 16'd31);
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_stall();
    int unsigned n;
    @(posedge clk_i);
    hold_req <= HOLD_LEN;
    cycle_limit += 2 * HOLD_LEN;
    for (n = 0; n < 8; n++) send_range(VB'($urandom_range(0, 3)), VB'($urandom_range(3, 6)));
  endtask

  // Mostly short ranges of small values, some narrow ranges of larger values, some empty noise
  task automatic test_random_mix();
    int unsigned     n;
    int unsigned     pick;
    logic [VB-1:0]   lo;
    logic [VB-1:0]   hi;
    for (n = 0; n < 75; n++) begin
      steady = (n < 25);
      pick = $urandom_range(99);
      if (pick < 70) begin
        hi = VB'($urandom_range(0, 40));
        lo = hi - VB'($urandom_range(0, (hi < 8) ? hi : 8));
      end else if (pick < 80) begin
        hi = VB'($urandom_range(60, 400));
        lo = hi - VB'($urandom_range(0, 2));
      end else begin
        lo = VB'($urandom_range(1, 65535));
        hi = VB'($urandom_range(0, lo - 1));
      end
      send_range(lo, hi);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ranges();
    test_small_ranges();
    test_output_stall();
    test_random_mix();

    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_results();
    cycle_limit += DRAIN_CYC + 16;
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (errors == 0) begin
      $display("sum_of_totients_top_tb: clean");
    end else begin
      $display("sum_of_totients_top_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
